### rtl/blist_pkg.sv
package blist_pkg;

  // Capacity of the store and derived widths
  localparam int DEPTH   = 16;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  // Port widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2 + ERR_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_FIND   = 3'd4
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

endpackage

### rtl/bounded_list_push_pop_remove_find.sv
// Channel  | Ports            | Contents
// ---------+------------------+---------------------------------------------
// in       | in_t*   (slave)  | one operation request: kind, operand_value
// out      | out_t*  (master) | one result per request: found, front, count,
//          |                  | error code
//
// Path: a request holds the block from its accept cycle up to the edge that
// loads the output register. Push, clear, unused kinds, both error cases, a
// pop that empties the store and remove or find on an empty store go from
// S_IDLE straight to S_RESP; any other pop passes S_FRONT to fetch the new
// front; remove and find walk every stored entry in S_WALK.
// The walk is set by the single read port of the entry memory: one
// entry read per cycle, compared in the next cycle by a shared comparator,
// after which the compare stage drains and the walk closes.
// Reset: synchronous, active low; the store comes up empty (head 0).
// Stalls: the result sits in an output register; a new request is taken
// while it waits, and the next result waits in S_RESP until it drains.
// in_tready is high only in S_IDLE.
module bounded_list_push_pop_remove_find (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [blist_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] operand_value
  input  logic [blist_pkg::IN_USER_W-1:0]    in_tuser,   // [2:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [blist_pkg::OUT_DATA_W-1:0]   out_tdata,  // [31:0] front_value,
                                                         // [36:32] entry_count,
                                                         // [39:37] zero
  output logic [blist_pkg::OUT_USER_W-1:0]   out_tuser   // [0] found,
                                                         // [1] front_valid,
                                                         // [3:2] error_code
);
  import blist_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FRONT,
    S_RESP
  } state_t;

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Store is a circular buffer: head_r points at the front entry,
  // entry i lives at head_r + i (mod DEPTH).
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, AW'(off)};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Entry memory: one write, one registered read per cycle
  logic [VALUE_W-1:0] store_mem [DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= store_mem[mem_raddr];
  end

  state_t             state_r,  state_nxt;
  logic [AW-1:0]      head_r,   head_nxt;
  logic [CW-1:0]      cnt_r,    cnt_nxt;
  logic [CW-1:0]      rd_r,     rd_nxt;    // next entry to read
  logic [CW-1:0]      wr_r,     wr_nxt;    // next compaction slot
  logic               chk_r,    chk_nxt;   // rdata_r holds an entry to check
  kind_t              kind_r,   kind_nxt;
  logic [VALUE_W-1:0] op_r,     op_nxt;
  logic [VALUE_W-1:0] front_r,  front_nxt;
  logic               found_r,  found_nxt;
  err_t               err_r,    err_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_USER_W-1:0] out_tuser_r, out_tuser_nxt;

  logic  in_acc;
  kind_t in_kind;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser[KIND_W-1:0]);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    chk_nxt        = chk_r;
    kind_nxt       = kind_r;
    op_nxt         = op_r;
    front_nxt      = front_r;
    found_nxt      = found_r;
    err_nxt        = err_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = op_r;
    mem_raddr      = head_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_kind;
          op_nxt    = in_tdata[VALUE_W-1:0];
          found_nxt = 1'b0;
          err_nxt   = ERR_NONE;
          rd_nxt    = '0;
          wr_nxt    = '0;
          chk_nxt   = 1'b0;
          state_nxt = S_RESP;
          unique case (in_kind)
            KIND_PUSH: begin
              if (cnt_r == DEPTH_C) begin
                err_nxt = ERR_FULL;
              end else begin
                head_nxt  = ptr_dec(head_r);
                mem_we    = 1'b1;
                mem_waddr = ptr_dec(head_r);
                mem_wdata = in_tdata[VALUE_W-1:0];
                front_nxt = in_tdata[VALUE_W-1:0];
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            KIND_POP: begin
              if (cnt_r == '0) begin
                err_nxt = ERR_EMPTY;
              end else begin
                head_nxt  = ptr_inc(head_r);
                cnt_nxt   = cnt_r - 1'b1;
                mem_raddr = ptr_inc(head_r);
                if (cnt_r != CW'(1)) begin
                  state_nxt = S_FRONT;
                end
              end
            end
            KIND_REMOVE, KIND_FIND: begin
              if (cnt_r != '0) begin
                state_nxt = S_WALK;
              end
            end
            KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // issue side: one read per cycle
        if (rd_r < cnt_r) begin
          mem_raddr = slot(head_r, rd_r);
          rd_nxt    = rd_r + 1'b1;
          chk_nxt   = 1'b1;
        end else begin
          chk_nxt   = 1'b0;
        end
        // check side: entry read last cycle
        if (chk_r) begin
          if (kind_r == KIND_FIND) begin
            if (rdata_r == op_r) begin
              found_nxt = 1'b1;
            end
          end else if (rdata_r != op_r) begin
            // survivor moves down; wr_r never passes rd_r
            mem_we    = 1'b1;
            mem_waddr = slot(head_r, wr_r);
            mem_wdata = rdata_r;
            wr_nxt    = wr_r + 1'b1;
            if (wr_r == '0) begin
              front_nxt = rdata_r;
            end
          end
        end
        if ((rd_r == cnt_r) && !chk_r) begin
          if (kind_r == KIND_REMOVE) begin
            cnt_nxt = wr_r;
          end
          state_nxt = S_RESP;
        end
      end

      S_FRONT: begin
        front_nxt = rdata_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tdata_nxt[VALUE_W-1:0] = (cnt_r != '0) ? front_r : '0;
          out_tdata_nxt[VALUE_W +: COUNT_W] = COUNT_W'(cnt_r);
          out_tuser_nxt  = {err_r, (cnt_r != '0), found_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      cnt_r        <= '0;
      rd_r         <= '0;
      wr_r         <= '0;
      chk_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
      rd_r         <= rd_nxt;
      wr_r         <= wr_nxt;
      chk_r        <= chk_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      kind_r       <= kind_nxt;
      op_r         <= op_nxt;
      front_r      <= front_nxt;
      found_r      <= found_nxt;
      err_r        <= err_nxt;
      out_tdata_r  <= out_tdata_nxt;
      out_tuser_r  <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (wr_r <= rd_r))
    else $error("compaction slot passed read index");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r[3:2] == ERR_FULL)) |->
      (out_tdata_r[VALUE_W +: COUNT_W] == COUNT_W'(DEPTH)))
    else $error("push-full error with store not full");

  a_found_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[0]) |-> (out_tuser_r[3:2] == ERR_NONE))
    else $error("found reported together with an error");

  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tuser_r[1] == (out_tdata_r[VALUE_W +: COUNT_W] != '0)))
    else $error("front valid flag disagrees with count");
`endif

endmodule
